FILE: rtl/timestamped_first_order_lowpass_defines.svh
// assertion macros for the timestamped first-order low-pass block
// no dependencies; included by files that carry concurrent checks
`ifndef TIMESTAMPED_FIRST_ORDER_LOWPASS_DEFINES_SVH
`define TIMESTAMPED_FIRST_ORDER_LOWPASS_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TFOL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfol: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define TFOL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfol: next-cycle check failed");

`endif

FILE: rtl/tfol_pkg.sv
// shared widths, register indexes and word types for the low-pass block
// no dependencies; imported by tfol_divmul and the top level
package tfol_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int ALPHA_FRAC_BITS = 16;
    localparam int TC_BITS         = 20;
    localparam int TIME_BITS       = 32;
    localparam int RESYNC_US       = 300000;

    // dt after the resync check fits in this many bits
    localparam int DT_BITS  = $clog2(RESYNC_US + 1);
    // tc + dt, with dt never wider than tc
    localparam int DEN_BITS = TC_BITS + 1;
    // (tc << F) + den/2
    localparam int NUM_BITS = TC_BITS + ALPHA_FRAC_BITS + 1;
    // alpha has one integer bit
    localparam int Q_BITS   = ALPHA_FRAC_BITS + 1;
    // exact product alpha * (last - sample)
    localparam int ACC_BITS = SAMPLE_BITS + 1 + Q_BITS + 1;
    localparam int CNT_BITS = $clog2(Q_BITS);

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TIME_CONSTANT  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_INITIAL_OUTPUT = CFG_INDEX_BITS'(1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [TIME_BITS-1:0]          now_us;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered;
        logic                          passed_through;
    } t_out_word;

    // control from the sequencer to the serial datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_dm_ctrl;

endpackage

FILE: rtl/timestamped_first_order_lowpass.sv
// top level of the timestamped first-order low-pass filter
// depends on tfol_pkg, tfol_divmul and the defines header
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+-------------------------------
//   in      | in        | i_in_valid / o_in_ready | i_in_word  (sample, now_us)
//   out     | out       | o_out_valid/ i_out_ready| o_out_word (filtered, passed)
//   cfg     | in        | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
// a filtered word passes from acceptance to o_out_valid through check, setup,
// 17 shared divide/multiply steps (one alpha bit each), one multiply tail and round.
// bypass and resync words go from the check state straight into the output register.
// a new word is accepted only once the result has moved into the output register.
// a stalled output holds the sequencer in its last state; reset is synchronous.
`include "timestamped_first_order_lowpass_defines.svh"

module timestamped_first_order_lowpass (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  tfol_pkg::t_in_word                     i_in_word,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output tfol_pkg::t_out_word                    o_out_word,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [tfol_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [tfol_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    import tfol_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_SETUP  = 6'b000100,
        S_DIV    = 6'b001000,
        S_MUL    = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state                        r_state, n_state;
    logic [CNT_BITS-1:0]           r_cnt;
    logic [TC_BITS-1:0]            r_tc;
    logic signed [SAMPLE_BITS-1:0] r_last_out;
    logic [TIME_BITS-1:0]          r_last_time;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [TIME_BITS-1:0]          r_now;
    logic [DT_BITS-1:0]            r_dt;
    logic                          r_out_valid;
    t_out_word                     r_out_word;

    logic                          in_acc;
    logic                          out_free;
    logic                          bypass;
    logic                          stale;
    logic [TIME_BITS-1:0]          dt_full;
    logic                          out_load;
    logic                          upd_state;
    logic                          cfg_tc;
    logic                          cfg_init;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] res_val;
    logic signed [ACC_BITS-1:0]    acc;
    t_dm_ctrl                      dm_ctrl;

    // handshakes
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_tc      = i_cfg_valid && (i_cfg_index == REG_TIME_CONSTANT);
    assign cfg_init    = i_cfg_valid && (i_cfg_index == REG_INITIAL_OUTPUT);

    // elapsed time and bypass decisions
    assign dt_full = r_now - r_last_time;
    assign stale   = (dt_full > TIME_BITS'(RESYNC_US));
    assign bypass  = (r_tc == '0);

    // round half up and add to the sample; the sum lies between sample and last
    assign y = r_x + acc[ALPHA_FRAC_BITS +: SAMPLE_BITS]
                   + SAMPLE_BITS'(acc[ALPHA_FRAC_BITS-1]);

    assign out_load  = out_free && (((r_state == S_CHECK) && (bypass || stale))
                                    || (r_state == S_FINISH));
    assign upd_state = out_load && !((r_state == S_CHECK) && bypass);
    assign res_val   = (r_state == S_FINISH) ? y : r_x;

    assign dm_ctrl.load = (r_state == S_SETUP);
    assign dm_ctrl.step = (r_state == S_DIV) || (r_state == S_MUL);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (bypass || stale) begin
                    if (out_free) n_state = S_IDLE;
                end else begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP:  n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == '0) n_state = S_MUL;
            end
            S_MUL:    n_state = S_FINISH;
            S_FINISH: begin
                if (out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_tc        <= '0;
            r_last_out  <= '0;
            r_last_time <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_tc) r_tc <= i_cfg_data[TC_BITS-1:0];
            if (cfg_init) begin
                r_last_out  <= i_cfg_data[SAMPLE_BITS-1:0];
                r_last_time <= '0;
            end else if (upd_state) begin
                r_last_out  <= res_val;
                r_last_time <= r_now;
            end
        end
    end

    // word capture, step counter, output word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x   <= i_in_word.sample;
            r_now <= i_in_word.now_us;
        end
        if (r_state == S_CHECK) r_dt <= dt_full[DT_BITS-1:0];
        if (r_state == S_SETUP) begin
            r_cnt <= CNT_BITS'(Q_BITS - 1);
        end else if (r_state == S_DIV) begin
            r_cnt <= r_cnt - CNT_BITS'(1);
        end
        if (out_load) begin
            r_out_word.filtered       <= res_val;
            r_out_word.passed_through <= (r_state == S_CHECK);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // serial alpha and product datapath
    tfol_divmul u_divmul (
        .i_clk    (i_clk),
        .i_ctrl   (dm_ctrl),
        .i_tc     (r_tc),
        .i_dt     (r_dt),
        .i_last   (r_last_out),
        .i_sample (r_x),
        .o_acc    (acc)
    );

    // checks
    `TFOL_ASSERT_NXT(a_div_to_mul, i_clk, i_rst_n, (r_state == S_DIV) && (r_cnt == '0), r_state == S_MUL)
    `TFOL_ASSERT_NXT(a_bypass_word, i_clk, i_rst_n, (r_state == S_CHECK) && bypass && out_free, o_out_valid && o_out_word.passed_through)
    `TFOL_ASSERT_NXT(a_time_held, i_clk, i_rst_n, !upd_state && !cfg_init, $stable(r_last_time))

endmodule

FILE: rtl/tfol_divmul.sv
// bit-serial alpha divider feeding a bit-serial multiplier
// depends on tfol_pkg; one quotient bit and one product step per cycle
module tfol_divmul (
    input  logic                                 i_clk,
    input  tfol_pkg::t_dm_ctrl                   i_ctrl,
    input  logic [tfol_pkg::TC_BITS-1:0]         i_tc,
    input  logic [tfol_pkg::DT_BITS-1:0]         i_dt,
    input  logic signed [tfol_pkg::SAMPLE_BITS-1:0] i_last,
    input  logic signed [tfol_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic signed [tfol_pkg::ACC_BITS-1:0] o_acc
);
    import tfol_pkg::*;

    logic [DEN_BITS-1:0]           r_den;
    logic [DEN_BITS-1:0]           r_rem;
    logic [Q_BITS-1:0]             r_num_lo;
    logic                          r_q;
    logic signed [SAMPLE_BITS:0]   r_diff;
    logic signed [ACC_BITS-1:0]    r_acc;

    logic [DEN_BITS-1:0]           den_sum;
    logic [NUM_BITS-1:0]           num_init;
    logic [DEN_BITS:0]             trial;
    logic                          take;
    logic signed [SAMPLE_BITS:0]   diff_next;
    logic signed [ACC_BITS-1:0]    addend;

    // setup values: denominator, rounded dividend, difference
    assign den_sum   = DEN_BITS'(i_tc) + DEN_BITS'(i_dt);
    assign num_init  = NUM_BITS'({i_tc, {ALPHA_FRAC_BITS{1'b0}}}) + NUM_BITS'(den_sum >> 1);
    assign diff_next = (SAMPLE_BITS + 1)'(i_last) - (SAMPLE_BITS + 1)'(i_sample);

    // restoring division step, dividend bits enter msb first
    assign trial = {r_rem, r_num_lo[Q_BITS-1]};
    assign take  = (trial >= {1'b0, r_den});

    // quotient bit from the previous step drives the msb-first multiply
    assign addend = r_q ? ACC_BITS'(r_diff) : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_den    <= den_sum;
            r_rem    <= DEN_BITS'(num_init[NUM_BITS-1 -: TC_BITS]);
            r_num_lo <= num_init[Q_BITS-1:0];
            r_q      <= 1'b0;
            r_diff   <= diff_next;
            r_acc    <= '0;
        end else if (i_ctrl.step) begin
            r_rem    <= take ? DEN_BITS'(trial - {1'b0, r_den}) : DEN_BITS'(trial);
            r_num_lo <= {r_num_lo[Q_BITS-2:0], 1'b0};
            r_q      <= take;
            r_acc    <= (r_acc <<< 1) + addend;
        end
    end

    assign o_acc = r_acc;

endmodule
